FILE: hw/rtl/rtip_pkg.sv
// ----------------------------------------------------------------------------
// rtip_pkg: shared definitions for the radix text-to-integer parser
// Parse phases, character constants, register indexes and field widths.
// ----------------------------------------------------------------------------
package rtip_pkg;

    // Field widths fixed by the interface.
    localparam int NUMBER_W   = 64;
    localparam int CONSUMED_W = 16;
    localparam int BYTE_W     = 8;
    localparam int RADIX_W    = 6;
    localparam int MODE_W     = 2;
    localparam int DIGIT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Default width of the internal byte counter.
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_BYTE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINUS_BYTE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLUS_BYTE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_CASE = 3'd5;

    // Register reset values.
    localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
    localparam logic [BYTE_W-1:0]  MINUS_RST = 8'd45;

    // Radix limits.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Fill modes and letter-case modes.
    localparam logic [MODE_W-1:0] FILL_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] CASE_BOTH  = 2'd0;
    localparam logic [MODE_W-1:0] CASE_UPPER = 2'd1;
    localparam logic [MODE_W-1:0] CASE_LOWER = 2'd2;

    // Character constants.
    localparam logic [BYTE_W-1:0] CHAR_0      = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_9      = 8'd57;
    localparam logic [BYTE_W-1:0] CHAR_UP_A   = 8'd65;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z   = 8'd90;
    localparam logic [BYTE_W-1:0] CHAR_LO_A   = 8'd97;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z   = 8'd122;
    localparam logic [BYTE_W-1:0] UPPER_OFFS  = 8'd55;
    localparam logic [BYTE_W-1:0] LOWER_OFFS  = 8'd87;

    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_FILL   = 2'd1,
        PH_SIGN   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

endpackage

FILE: hw/rtl/radix_text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// radix_text_to_integer_parser: streaming text-to-integer parser, base 2..36
// Parses one text byte per beat and returns one signed 64-bit result for
// each finished number, with the count of consumed bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one text byte per beat in s_axis_tdata, and
// s_axis_tuser marks the first byte of a new number. Leading fill bytes
// are skipped in left-fill mode, then an optional minus or plus byte is
// taken, then digits. The first byte that is not part of the number ends
// it; that byte is not consumed and one result beat is sent on the master
// side: the value (negated modulo 2^64 after a minus byte) and the byte
// count in m_axis_tdata, and a bad-radix flag in m_axis_tuser. A start
// byte that arrives while the radix is outside 2..36 yields a result of
// zero with the flag set right away.
// A beat is held in the input register; a digit goes through the
// multiply-add by the radix into the accumulator, and a byte that
// ends a number loads the result register. Throughput is one byte per
// cycle; the 64 by 6 bit multiply-add sets the critical path. When the
// receiver stalls, other bytes keep flowing; a byte that ends a number
// waits in the input register until the result register frees up.
// Reset clears the configuration to its defaults and leaves the parser
// waiting for a start byte. The user must write cfg_we, cfg_index and
// cfg_data only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module radix_text_to_integer_parser #(
    parameter int COUNT_WIDTH = rtip_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [rtip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtip_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] text_byte
    input  logic                              s_axis_tuser,   // [0] start_text
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [79:0]                       m_axis_tdata,   // [63:0] number, [79:64] consumed
    output logic                              m_axis_tuser    // [0] bad_radix
);

    // Configuration registers.
    logic [rtip_pkg::RADIX_W-1:0] radix_reg;
    logic [rtip_pkg::BYTE_W-1:0]  fill_byte_reg;
    logic [rtip_pkg::BYTE_W-1:0]  minus_byte_reg;
    logic [rtip_pkg::BYTE_W-1:0]  plus_byte_reg;
    logic [rtip_pkg::MODE_W-1:0]  fill_mode_reg;
    logic [rtip_pkg::MODE_W-1:0]  letter_case_reg;

    // Input register.
    logic                         in_valid_reg;
    logic [rtip_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         in_start_reg;

    // Parser state.
    rtip_pkg::phase_t                 phase_reg, phase_next;
    logic [rtip_pkg::NUMBER_W-1:0]    acc_reg, acc_next;
    logic                             neg_reg, neg_next;
    logic [COUNT_WIDTH-1:0]           count_reg, count_next;

    // Result register.
    logic                             out_valid_reg;
    logic [rtip_pkg::NUMBER_W-1:0]    out_number_reg, out_number_next;
    logic [rtip_pkg::CONSUMED_W-1:0]  out_consumed_reg, out_consumed_next;
    logic                             out_bad_reg, out_bad_next;

    // Per-byte decode.
    logic                             radix_ok;
    logic                             left_fill;
    rtip_pkg::phase_t                 phase_eff;
    logic [rtip_pkg::NUMBER_W-1:0]    acc_base;
    logic                             neg_base;
    logic [COUNT_WIDTH-1:0]           count_base;
    logic [COUNT_WIDTH-1:0]           count_inc;
    logic [COUNT_WIDTH+rtip_pkg::CONSUMED_W-1:0] count_ext;
    logic [rtip_pkg::DIGIT_W-1:0]     digit;
    logic                             digit_ok;
    logic [rtip_pkg::NUMBER_W-1:0]    mac;
    logic                             fill_hit;
    logic                             sign_stage;
    logic                             emit;
    logic                             out_free;
    logic                             proc_fire;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= rtip_pkg::RADIX_RST;
            fill_byte_reg   <= '0;
            minus_byte_reg  <= rtip_pkg::MINUS_RST;
            plus_byte_reg   <= '0;
            fill_mode_reg   <= rtip_pkg::FILL_LEFT;
            letter_case_reg <= rtip_pkg::CASE_BOTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtip_pkg::REG_RADIX:       radix_reg       <= cfg_data[rtip_pkg::RADIX_W-1:0];
                rtip_pkg::REG_FILL_BYTE:   fill_byte_reg   <= cfg_data;
                rtip_pkg::REG_MINUS_BYTE:  minus_byte_reg  <= cfg_data;
                rtip_pkg::REG_PLUS_BYTE:   plus_byte_reg   <= cfg_data;
                rtip_pkg::REG_FILL_MODE:   fill_mode_reg   <= cfg_data[rtip_pkg::MODE_W-1:0];
                rtip_pkg::REG_LETTER_CASE: letter_case_reg <= cfg_data[rtip_pkg::MODE_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. The held byte is processed unless it ends a number and
    // the result register is still occupied.
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && (!emit || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Byte decode: start handling, digit value, multiply-add.
    // ------------------------------------------------------------------
    assign radix_ok  = (radix_reg >= rtip_pkg::RADIX_MIN)
                       && (radix_reg <= rtip_pkg::RADIX_MAX);
    assign left_fill = (fill_byte_reg != '0) && (fill_mode_reg == rtip_pkg::FILL_LEFT);

    assign acc_base   = in_start_reg ? '0   : acc_reg;
    assign neg_base   = in_start_reg ? 1'b0 : neg_reg;
    assign count_base = in_start_reg ? '0   : count_reg;
    assign count_inc  = (count_base == {COUNT_WIDTH{1'b1}}) ? count_base
                                                            : count_base + COUNT_WIDTH'(1);
    assign count_ext  = {{rtip_pkg::CONSUMED_W{1'b0}}, count_base};

    always_comb
    begin
        if (in_start_reg)
            phase_eff = left_fill ? rtip_pkg::PH_FILL : rtip_pkg::PH_SIGN;
        else
            phase_eff = phase_reg;
    end

    always_comb
    begin
        logic [rtip_pkg::BYTE_W-1:0] raw;
        logic                        is_digit;
        raw      = '0;
        is_digit = 1'b0;
        if (in_byte_reg >= rtip_pkg::CHAR_0 && in_byte_reg <= rtip_pkg::CHAR_9)
        begin
            raw      = in_byte_reg - rtip_pkg::CHAR_0;
            is_digit = 1'b1;
        end
        else if (in_byte_reg >= rtip_pkg::CHAR_UP_A && in_byte_reg <= rtip_pkg::CHAR_UP_Z
                 && letter_case_reg != rtip_pkg::CASE_LOWER)
        begin
            raw      = in_byte_reg - rtip_pkg::UPPER_OFFS;
            is_digit = 1'b1;
        end
        else if (in_byte_reg >= rtip_pkg::CHAR_LO_A && in_byte_reg <= rtip_pkg::CHAR_LO_Z
                 && letter_case_reg != rtip_pkg::CASE_UPPER)
        begin
            raw      = in_byte_reg - rtip_pkg::LOWER_OFFS;
            is_digit = 1'b1;
        end
        digit    = raw[rtip_pkg::DIGIT_W-1:0];
        digit_ok = is_digit && (digit < radix_reg);
    end

    // The radix has only six significant bits, so this is a 64 by 6 multiply.
    assign mac = acc_base * {{(rtip_pkg::NUMBER_W-rtip_pkg::RADIX_W){1'b0}}, radix_reg}
               + {{(rtip_pkg::NUMBER_W-rtip_pkg::DIGIT_W){1'b0}}, digit};

    assign fill_hit   = (phase_eff == rtip_pkg::PH_FILL) && left_fill
                        && (in_byte_reg == fill_byte_reg);
    assign sign_stage = (phase_eff == rtip_pkg::PH_SIGN)
                        || ((phase_eff == rtip_pkg::PH_FILL) && !fill_hit);

    // ------------------------------------------------------------------
    // Next state and result.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next        = phase_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        count_next        = count_reg;
        emit              = 1'b0;
        out_number_next   = '0;
        out_consumed_next = '0;
        out_bad_next      = 1'b0;

        if (in_valid_reg)
        begin
            acc_next   = acc_base;
            neg_next   = neg_base;
            count_next = count_base;
            if (!radix_ok && (in_start_reg || phase_eff != rtip_pkg::PH_DONE))
            begin
                // Invalid base: zero result with the flag, parser goes idle.
                emit         = 1'b1;
                out_bad_next = 1'b1;
                phase_next   = rtip_pkg::PH_DONE;
            end
            else if (phase_eff == rtip_pkg::PH_DONE)
            begin
                phase_next = rtip_pkg::PH_DONE;
            end
            else if (fill_hit)
            begin
                phase_next = rtip_pkg::PH_FILL;
                count_next = count_inc;
            end
            else if (sign_stage && minus_byte_reg != '0 && in_byte_reg == minus_byte_reg)
            begin
                phase_next = rtip_pkg::PH_DIGITS;
                neg_next   = 1'b1;
                count_next = count_inc;
            end
            else if (sign_stage && plus_byte_reg != '0 && in_byte_reg == plus_byte_reg)
            begin
                phase_next = rtip_pkg::PH_DIGITS;
                count_next = count_inc;
            end
            else if (digit_ok)
            begin
                phase_next = rtip_pkg::PH_DIGITS;
                acc_next   = mac;
                count_next = count_inc;
            end
            else
            begin
                // Terminator: not consumed, the number is finished.
                emit              = 1'b1;
                phase_next        = rtip_pkg::PH_DONE;
                out_number_next   = neg_base ? ('0 - acc_base) : acc_base;
                out_consumed_next = count_ext[rtip_pkg::CONSUMED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rtip_pkg::PH_DONE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (proc_fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && emit)
        begin
            out_number_reg   <= out_number_next;
            out_consumed_reg <= out_consumed_next;
            out_bad_reg      <= out_bad_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_consumed_reg, out_number_reg};
    assign m_axis_tuser  = out_bad_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("bad-radix result carries a nonzero payload");

    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && emit) |=> (phase_reg == rtip_pkg::PH_DONE))
        else $error("parser not idle after a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("pending result dropped");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && !in_start_reg) |=> (count_reg >= $past(count_reg)))
        else $error("byte count decreased within a number");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radix text-to-integer parser
// Streams text beats into the parser and predicts each result beat with a
// bit-exact behavioral parser kept in a small scoreboard class. Covers
// directed corner cases, live configuration changes and long runs of
// random numbers under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    // Run limits and stimulus sizes.
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int RANDOM_BEATS  = 1300;
    localparam int QUIET_BEATS   = 1100;   // idling stops past this point
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;      // settling time at the end of a phase

    localparam logic [rtip_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int                             NO_DIGIT   = 64;

    typedef struct packed {
        logic [rtip_pkg::NUMBER_W-1:0]   number;
        logic [rtip_pkg::CONSUMED_W-1:0] consumed;
        logic                            bad_radix;
    } parse_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioral copy of the parser plus the queue of results
    // it has promised. Register writes land here at the same edge as in
    // the block, and every accepted text beat is run through parse_byte.
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        bit [rtip_pkg::RADIX_W-1:0]    radix;
        bit [rtip_pkg::BYTE_W-1:0]     fill_char;
        bit [rtip_pkg::BYTE_W-1:0]     minus_char;
        bit [rtip_pkg::BYTE_W-1:0]     plus_char;
        bit [rtip_pkg::MODE_W-1:0]     fill_mode;
        bit [rtip_pkg::MODE_W-1:0]     case_mode;

        rtip_pkg::phase_t              phase;
        bit [rtip_pkg::NUMBER_W-1:0]   acc;
        bit                            neg;
        bit [rtip_pkg::CONSUMED_W-1:0] count;

        parse_result_t                 expected_results[$];
        int                            mismatch_count;

        function new();
            radix          = rtip_pkg::RADIX_RST;
            fill_char      = '0;
            minus_char     = rtip_pkg::MINUS_RST;
            plus_char      = '0;
            fill_mode      = rtip_pkg::FILL_LEFT;
            case_mode      = rtip_pkg::CASE_BOTH;
            phase          = rtip_pkg::PH_DONE;
            acc            = '0;
            neg            = 1'b0;
            count          = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [rtip_pkg::CFG_IDX_W-1:0] idx,
                                   logic [rtip_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                rtip_pkg::REG_RADIX:       radix      = val[rtip_pkg::RADIX_W-1:0];
                rtip_pkg::REG_FILL_BYTE:   fill_char  = val;
                rtip_pkg::REG_MINUS_BYTE:  minus_char = val;
                rtip_pkg::REG_PLUS_BYTE:   plus_char  = val;
                rtip_pkg::REG_FILL_MODE:   fill_mode  = val[rtip_pkg::MODE_W-1:0];
                rtip_pkg::REG_LETTER_CASE: case_mode  = val[rtip_pkg::MODE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit radix_valid();
            return radix >= rtip_pkg::RADIX_MIN && radix <= rtip_pkg::RADIX_MAX;
        endfunction

        function void count_up();
            if (count != '1)
                count++;
        endfunction

        // Digit value of a character in the current base, or NO_DIGIT.
        function int digit_value(bit [rtip_pkg::BYTE_W-1:0] ch);
            int d;
            d = NO_DIGIT;
            if (ch >= rtip_pkg::CHAR_0 && ch <= rtip_pkg::CHAR_9)
                d = int'(ch) - int'(rtip_pkg::CHAR_0);
            else if (ch >= rtip_pkg::CHAR_UP_A && ch <= rtip_pkg::CHAR_UP_Z
                     && case_mode != rtip_pkg::CASE_LOWER)
                d = int'(ch) - int'(rtip_pkg::UPPER_OFFS);
            else if (ch >= rtip_pkg::CHAR_LO_A && ch <= rtip_pkg::CHAR_LO_Z
                     && case_mode != rtip_pkg::CASE_UPPER)
                d = int'(ch) - int'(rtip_pkg::LOWER_OFFS);
            if (d >= int'(radix))
                d = NO_DIGIT;
            return d;
        endfunction

        function void push_result(bit [rtip_pkg::NUMBER_W-1:0] num,
                                  bit [rtip_pkg::CONSUMED_W-1:0] cnt, bit bad);
            parse_result_t r;
            r.number    = num;
            r.consumed  = cnt;
            r.bad_radix = bad;
            expected_results.push_back(r);
            phase = rtip_pkg::PH_DONE;
        endfunction

        // Advances the parser by one accepted text beat.
        function void parse_byte(bit [rtip_pkg::BYTE_W-1:0] ch, bit first);
            int d;
            if (first) begin
                acc   = '0;
                neg   = 1'b0;
                count = '0;
                if (!radix_valid()) begin
                    push_result('0, '0, 1'b1);
                    return;
                end
                phase = (fill_char != 0 && fill_mode == rtip_pkg::FILL_LEFT)
                        ? rtip_pkg::PH_FILL : rtip_pkg::PH_SIGN;
            end
            if (phase == rtip_pkg::PH_DONE)
                return;
            // The radix can go bad between bytes of one number.
            if (!radix_valid()) begin
                push_result('0, '0, 1'b1);
                return;
            end
            if (phase == rtip_pkg::PH_FILL) begin
                if (fill_char != 0 && fill_mode == rtip_pkg::FILL_LEFT && ch == fill_char) begin
                    count_up();
                    return;
                end
                phase = rtip_pkg::PH_SIGN;
            end
            if (phase == rtip_pkg::PH_SIGN) begin
                phase = rtip_pkg::PH_DIGITS;
                if (minus_char != 0 && ch == minus_char) begin
                    neg = 1'b1;
                    count_up();
                    return;
                end
                if (plus_char != 0 && ch == plus_char) begin
                    count_up();
                    return;
                end
            end
            d = digit_value(ch);
            if (d != NO_DIGIT) begin
                acc = acc * rtip_pkg::NUMBER_W'(radix) + rtip_pkg::NUMBER_W'(d);
                count_up();
                return;
            end
            // The terminating byte is not consumed.
            push_result(neg ? (rtip_pkg::NUMBER_W'(0) - acc) : acc, count, 1'b0);
        endfunction

        function void check_result(logic [rtip_pkg::NUMBER_W-1:0] num,
                                   logic [rtip_pkg::CONSUMED_W-1:0] cnt, logic bad);
            parse_result_t exp_r;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat: number=%h consumed=%0d bad_radix=%b",
                             num, cnt, bad);
                return;
            end
            exp_r = expected_results.pop_front();
            if (num !== exp_r.number || cnt !== exp_r.consumed || bad !== exp_r.bad_radix) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"Result mismatch: expected number=%h consumed=%0d bad_radix=%b,",
                              " got number=%h consumed=%0d bad_radix=%b"},
                             exp_r.number, exp_r.consumed, exp_r.bad_radix, num, cnt, bad);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals. Every input has a known value from
    // time zero; reset is held low from the start and released once.
    // ------------------------------------------------------------------------
    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [rtip_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [rtip_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata  = '0;   // [7:0] text_byte
    logic                            s_axis_tuser  = 1'b0; // [0] start_text
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [79:0]                     m_axis_tdata;  // [63:0] number, [79:64] consumed
    logic                            m_axis_tuser;  // [0] bad_radix

    parse_scoreboard sb = new();

    // Idling controls for the sender and the receiver.
    bit tx_idle       = 1'b1;
    bit rx_idle       = 1'b1;
    bit long_hold_req = 1'b0;
    int random_beats  = 0;
    int cycle_count   = 0;

    // Radix settings forced on the first random phases: both ends of the
    // valid range and several invalid values, some with the upper data bits set.
    logic [rtip_pkg::CFG_DATA_W-1:0] forced_radix [6] =
        '{8'd2, 8'hE4, 8'hFF, 8'hC0, 8'h41, 8'd37};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    radix_text_to_integer_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The watchdog ends a run that hangs, for instance on a lost handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Each edge first checks the beat that was handshaken at
    // it, then decides tready for the next cycle. Stalls come in short
    // random bursts, plus one long hold-off on request that backs the
    // block up until it stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[63:0], m_axis_tdata[79:64], m_axis_tuser);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0) begin
                stall_left    = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. All of them are entered right after a rising edge.
    // ------------------------------------------------------------------------

    // Offers one text beat and returns at the edge that accepts it. A gap,
    // when taken, drops tvalid first so it never falls and rises at once.
    task automatic send_beat(logic [7:0] ch, logic first);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= first;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.parse_byte(ch, first);
        random_beats = random_beats + 1;
    endtask

    // Sends a string with the start flag on its first byte.
    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], i == 0);
    endtask

    // Ends a phase: the stream goes quiet, every promised result is
    // collected, and a byte still in the pipe without a result is given
    // time to pass before the registers may change.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_we after its last write.
    task automatic cfg_write(logic [rtip_pkg::CFG_IDX_W-1:0] idx,
                             logic [rtip_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_register(idx, val);
    endtask

    // Picks a fresh setting for every register. Mode registers get random
    // upper bits, which the block drops.
    task automatic random_config(int phase_no);
        logic [rtip_pkg::CFG_DATA_W-1:0] val;
        if (phase_no < 6)
            val = forced_radix[phase_no];
        else if ($urandom_range(0, 4) != 0)
            val = {2'($urandom), 6'($urandom_range(2, 36))};
        else
            val = 8'($urandom);
        cfg_write(rtip_pkg::REG_RADIX, val);
        case ($urandom_range(0, 4))
            0:       val = 8'd0;
            1:       val = "*";
            2:       val = " ";
            3:       val = rtip_pkg::CHAR_0;
            default: val = 8'($urandom);
        endcase
        cfg_write(rtip_pkg::REG_FILL_BYTE, val);
        case ($urandom_range(0, 3))
            0:       val = 8'd0;
            1:       val = 8'($urandom);
            default: val = "-";
        endcase
        cfg_write(rtip_pkg::REG_MINUS_BYTE, val);
        case ($urandom_range(0, 3))
            0:       val = 8'd0;
            1:       val = 8'($urandom);
            default: val = "+";
        endcase
        cfg_write(rtip_pkg::REG_PLUS_BYTE, val);
        cfg_write(rtip_pkg::REG_FILL_MODE, 8'($urandom));
        cfg_write(rtip_pkg::REG_LETTER_CASE, 8'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Character for a digit value, in a random letter case.
    function automatic logic [7:0] digit_char(int v);
        if (v < 10)
            return 8'(int'(rtip_pkg::CHAR_0) + v);
        if ($urandom_range(0, 1) != 0)
            return 8'(int'(rtip_pkg::CHAR_UP_A) + v - 10);
        return 8'(int'(rtip_pkg::CHAR_LO_A) + v - 10);
    endfunction

    // One mostly well-formed number: optional fill, optional sign, digits
    // of the current base and a terminator. Now and then a digit is
    // replaced by a random byte, or the terminator is left out so that the
    // next start abandons the number.
    task automatic send_random_number();
        int         n_fill;
        int         n_dig;
        int         base_lim;
        logic [7:0] ch;
        bit         first;
        first    = 1'b1;
        base_lim = sb.radix_valid() ? int'(sb.radix) : 36;
        n_fill   = (sb.fill_char != 0 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        repeat (n_fill) begin
            send_beat(sb.fill_char, first);
            first = 1'b0;
        end
        case ($urandom_range(0, 5))
            0: begin
                send_beat((sb.minus_char != 0) ? sb.minus_char : 8'("-"), first);
                first = 1'b0;
            end
            1: begin
                send_beat((sb.plus_char != 0) ? sb.plus_char : 8'("+"), first);
                first = 1'b0;
            end
            default: ;
        endcase
        n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 12);
        repeat (n_dig) begin
            if ($urandom_range(0, 15) == 0)
                ch = 8'($urandom);
            else
                ch = digit_char($urandom_range(0, base_lim - 1));
            send_beat(ch, first);
            first = 1'b0;
        end
        if (first || $urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 3))
                0:       ch = " ";
                1:       ch = ",";
                2:       ch = ";";
                default: ch = 8'($urandom);
            endcase
            send_beat(ch, first);
        end
        // Stray bytes: mostly ignored, sometimes a lone start byte.
        if ($urandom_range(0, 11) == 0)
            send_beat(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int phase_no;
        int phase_end;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: base 10, minus enabled, plus and fill disabled.
        send_text("-7x");          // negative number, terminator not consumed
        send_beat("z", 1'b0);      // a byte while done is ignored
        send_text("-,");           // sign without digits
        send_text("12");           // abandoned by the next start byte
        send_text("3 ");
        send_text("+1");           // plus disabled, so it ends the number at once
        finish_phase();

        // Base 36 with left fill and a plus byte; the unused index is ignored.
        cfg_write(rtip_pkg::REG_RADIX, 8'd36);
        cfg_write(rtip_pkg::REG_FILL_BYTE, "*");
        cfg_write(rtip_pkg::REG_PLUS_BYTE, "+");
        cfg_write(REG_UNUSED, 8'hA5);
        cfg_we <= 1'b0;
        send_text("*+zZ!");
        finish_phase();

        // A number is left open, then the radix turns invalid under it.
        cfg_write(rtip_pkg::REG_RADIX, 8'd10);
        cfg_we <= 1'b0;
        send_text("12");
        finish_phase();
        cfg_write(rtip_pkg::REG_RADIX, 8'd40);
        cfg_we <= 1'b0;
        send_beat("3", 1'b0);
        send_text("5");            // a start byte under a bad radix
        finish_phase();

        // Random phases, each under a new register setting. The long
        // receiver hold-off falls in the fourth one.
        phase_no = 0;
        while (random_beats < RANDOM_BEATS) begin
            random_config(phase_no);
            tx_idle   = (random_beats < QUIET_BEATS);
            rx_idle   = (random_beats < QUIET_BEATS);
            phase_end = random_beats + $urandom_range(60, 140);
            if (phase_no == 3)
                long_hold_req = 1'b1;
            while (random_beats < phase_end)
                send_random_number();
            finish_phase();
            phase_no++;
        end

        repeat (20) @(posedge clk);
        if (sb.expected_results.size() != 0)
            $display("%0d expected results never arrived", sb.expected_results.size());
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
